// ===== rtl/wind_speed_running_stats_unit_defines.svh =====
// ---------------------------------------------------------------------------
// wind speed running stats - assertion macros
// concurrent assertion wrappers, removable by defining NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef WIND_SPEED_RUNNING_STATS_UNIT_DEFINES_SVH
`define WIND_SPEED_RUNNING_STATS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define WSRS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("wsrs assertion failed");
// property checked at every edge, reset included
`define WSRS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("wsrs assertion failed");
`else
`define WSRS_ASSERT(name, clk, rstn, prop)
`define WSRS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/wsrs_pkg.sv =====
// ---------------------------------------------------------------------------
// wsrs_pkg
// shared widths, constants and interface structs of the running stats unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsrs_pkg;

    localparam int TB_W     = 21;
    localparam int PERIOD_W = 24;
    localparam int SPEED_W  = 27;
    localparam int ACC_W    = 32;
    localparam int SCALED_W = 28;

    localparam logic [TB_W-1:0]    TB_RESET  = 21'd32768;
    localparam logic [SPEED_W-1:0] SPEED_SAT = {SPEED_W{1'b1}};
    localparam logic [ACC_W-1:0]   COUNT_SAT = {ACC_W{1'b1}};

    // register index decoded from paddr[2]
    localparam logic REG_TIMEBASE = 1'b0;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [ACC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               en;
        logic               clr;
        logic [SPEED_W-1:0] speed;
    } stat_upd_t;

    typedef struct packed {
        logic [SPEED_W-1:0] min_shown;
        logic [SPEED_W-1:0] max_val;
        logic [ACC_W-1:0]   sum;
        logic [ACC_W-1:0]   count;
    } stat_view_t;

endpackage

// ===== rtl/wsrs_div.sv =====
// ---------------------------------------------------------------------------
// wsrs_div
// bit-serial restoring divider, one quotient bit per cycle while a division runs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsrs_div
    import wsrs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [ACC_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ACC_W:0] rem_shift;
    logic [ACC_W:0] diff;

    // shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[ACC_W]) begin
                rem_next = diff[ACC_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[ACC_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ACC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/wsrs_stats.sv =====
// ---------------------------------------------------------------------------
// wsrs_stats
// running minimum, maximum, wrapping sum and saturating count of speeds
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsrs_stats
    import wsrs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  stat_upd_t  upd,
    output stat_view_t view
);

    logic               min_set_reg, min_set_next;
    logic [SPEED_W-1:0] min_reg, min_next;
    logic [SPEED_W-1:0] max_reg, max_next;
    logic [ACC_W-1:0]   sum_reg, sum_next;
    logic [ACC_W-1:0]   cnt_reg, cnt_next;

    logic               base_set;
    logic [SPEED_W-1:0] base_min;
    logic [SPEED_W-1:0] base_max;
    logic [ACC_W-1:0]   base_sum;
    logic [ACC_W-1:0]   base_cnt;

    always_comb begin
        // clear comes before the sample is folded in
        base_set = upd.clr ? 1'b0 : min_set_reg;
        base_min = min_reg;
        base_max = upd.clr ? '0 : max_reg;
        base_sum = upd.clr ? '0 : sum_reg;
        base_cnt = upd.clr ? '0 : cnt_reg;

        min_set_next = min_set_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        if (upd.en) begin
            min_set_next = 1'b1;
            min_next     = (!base_set || upd.speed < base_min) ? upd.speed : base_min;
            max_next     = (upd.speed > base_max) ? upd.speed : base_max;
            sum_next     = base_sum + ACC_W'(upd.speed);
            cnt_next     = (base_cnt == COUNT_SAT) ? base_cnt : base_cnt + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_set_reg <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            min_set_reg <= min_set_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
        end
    end

    // a minimum never set reads as zero
    assign view.min_shown = min_set_reg ? min_reg : '0;
    assign view.max_val   = max_reg;
    assign view.sum       = sum_reg;
    assign view.count     = cnt_reg;

endmodule

// ===== rtl/wind_speed_running_stats_unit.sv =====
// ---------------------------------------------------------------------------
// wind_speed_running_stats_unit
// pulse period to speed conversion with running min, max and mean
// ---------------------------------------------------------------------------
//  channel  | ports            | payload
//  ---------+------------------+----------------------------------------------
//  input    | s_tvalid/s_tready | period_ticks in tdata, clear_stats in tuser
//  result   | m_tvalid/m_tready | speed, speed_mean, speed_min, speed_max
//  config   | apb psel/penable  | timebase_hz at byte address 0
//
//  one item at a time; the result follows the input transfer through the
//  bit-serial divider, which runs twice (speed then mean), with states for
//  the stats update, the mean start and the output load in between.
//  a zero period skips the first division and goes to the stats update.
//  reset is synchronous, active low, and restores timebase 32768 and
//  empty statistics. a result waiting at the output holds the unit in its
//  final state; the output register lets the next input transfer in once
//  the result is loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wind_speed_running_stats_unit_defines.svh"

module wind_speed_running_stats_unit
    import wsrs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [23:0] period_ticks
    input  logic [0:0]   s_tuser,   // [0] clear_stats
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [26:0] speed, [53:27] speed_mean,
                                    // [80:54] speed_min, [107:81] speed_max
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_SPEED,
        S_STATS,
        S_MEAN_START,
        S_DIV_MEAN,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [TB_W-1:0]    tb_reg, tb_next;
    logic               clr_reg, clr_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [SPEED_W-1:0] mean_reg, mean_next;
    logic               out_valid_reg, out_valid_next;
    logic [111:0]       out_data_reg, out_data_next;

    logic               in_xfer;
    logic               cfg_write;
    logic               out_free;
    logic [SCALED_W-1:0] scaled_tb;
    logic [SPEED_W-1:0] speed_sat;

    div_req_t   div_req;
    div_rsp_t   div_rsp;
    stat_upd_t  stat_upd;
    stat_view_t stat_view;

    // apb: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEBASE);
    assign prdata    = (paddr[2] == REG_TIMEBASE) ? 32'(tb_reg) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // 100 * timebase as shifts and adds: 64 + 32 + 4
    assign scaled_tb = {1'b0, tb_reg, 6'b0}
                     + {2'b0, tb_reg, 5'b0}
                     + {5'b0, tb_reg, 2'b0};

    // quotient above 27 bits clamps to full scale
    assign speed_sat = (div_rsp.quotient[ACC_W-1:SPEED_W] != '0)
                     ? SPEED_SAT : div_rsp.quotient[SPEED_W-1:0];

    // divider requests: speed on input transfer, mean after the stats update
    always_comb begin
        div_req = '0;
        if (in_xfer && (s_tdata[PERIOD_W-1:0] != '0)) begin
            div_req.start    = 1'b1;
            div_req.dividend = ACC_W'(scaled_tb);
            div_req.divisor  = ACC_W'(s_tdata[PERIOD_W-1:0]);
        end else if (state_reg == S_MEAN_START) begin
            div_req.start    = 1'b1;
            div_req.dividend = stat_view.sum;
            div_req.divisor  = stat_view.count;
        end
    end

    assign stat_upd.en    = (state_reg == S_STATS);
    assign stat_upd.clr   = clr_reg;
    assign stat_upd.speed = speed_reg;

    always_comb begin
        state_next     = state_reg;
        tb_next        = cfg_write ? pwdata[TB_W-1:0] : tb_reg;
        clr_next       = clr_reg;
        speed_next     = speed_reg;
        mean_next      = mean_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // result leaves on its transfer
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    clr_next = s_tuser[0];
                    if (s_tdata[PERIOD_W-1:0] == '0) begin
                        // no pulse: speed is zero, still counted as a sample
                        speed_next = '0;
                        state_next = S_STATS;
                    end else begin
                        state_next = S_DIV_SPEED;
                    end
                end
            end
            S_DIV_SPEED: begin
                if (div_rsp.done) begin
                    speed_next = speed_sat;
                    state_next = S_STATS;
                end
            end
            S_STATS: begin
                state_next = S_MEAN_START;
            end
            S_MEAN_START: begin
                state_next = S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
                if (div_rsp.done) begin
                    mean_next  = div_rsp.quotient[SPEED_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, stat_view.max_val, stat_view.min_shown,
                                      mean_reg, speed_reg};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            tb_reg        <= TB_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tb_reg        <= tb_next;
            out_valid_reg <= out_valid_next;
        end
        clr_reg      <= clr_next;
        speed_reg    <= speed_next;
        mean_reg     <= mean_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    wsrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    wsrs_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (stat_upd),
        .view    (stat_view)
    );

    // only one item in flight
    `WSRS_ASSERT(a_one_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    // the divider only runs while a division state waits on it
    `WSRS_ASSERT(a_div_owner, aclk, aresetn, div_rsp.busy |-> (state_reg == S_DIV_SPEED || state_reg == S_DIV_MEAN))
    // a new result appears only from the final state
    `WSRS_ASSERT(a_out_source, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == S_OUT))
    // shown minimum never exceeds the maximum
    `WSRS_ASSERT(a_min_le_max, aclk, aresetn, stat_view.min_shown <= stat_view.max_val)
    // configuration port never inserts wait states
    `WSRS_ASSERT_ALWAYS(a_pready_high, aclk, pready)

endmodule

// ===== verif/tb_wind_speed_running_stats_unit.sv =====
// ---------------------------------------------------------------------------
// tb_wind_speed_running_stats_unit
// self-checking bench for the period to speed unit with running statistics
//
// items go in on the s_ stream and the m_ results are checked field by field
// against an in-bench predictor of speed, mean, minimum and maximum.
// directed tests cover the reset state, the timebase extremes and a wrapping
// sum. random phases then send runs of periods at several timebase settings,
// with random input gaps and random back-pressure on the result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wind_speed_running_stats_unit
    import wsrs_pkg::*;
();

    // scaling and limits of the speed computation
    localparam logic [31:0] SPEED_SCALE   = 32'd100;
    localparam logic [31:0] MIN_EMPTY     = 32'hFFFF_FFFF;
    localparam logic [2:0]  ADDR_TIMEBASE = {REG_TIMEBASE, 2'b00};
    localparam logic [TB_W-1:0] TB_MAX    = {TB_W{1'b1}};
    localparam int IDLE_PCT     = 21;
    localparam int STALL_LIMIT  = 4000;   // cycles without any transfer
    localparam int TAIL_CYCLES  = 150;    // quiet time after the last result
    localparam int PHASE_ITEMS  = 130;

    // one expected result record
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] mean;
        logic [SPEED_W-1:0] min_shown;
        logic [SPEED_W-1:0] max_val;
    } speed_stats_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream, all driven from time zero
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata  = '0;   // [23:0] period_ticks
    logic [0:0]          s_tuser  = '0;   // [0] clear_stats

    // result stream
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [111:0]        m_tdata;         // [26:0] speed, [53:27] speed_mean,
                                          // [80:54] speed_min, [107:81] speed_max

    // configuration port
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state, mirrors the unit's register and statistics
    logic [TB_W-1:0]     cfg_timebase;
    logic [ACC_W-1:0]    stat_min;
    logic [ACC_W-1:0]    stat_max;
    logic [ACC_W-1:0]    stat_sum;
    logic [ACC_W-1:0]    stat_count;

    // results still owed by the unit, oldest first
    speed_stats_t        pending_stats[$];

    // bookkeeping
    bit                  idle_en = 1'b1;
    int                  mismatches;
    int                  items_sent;
    int                  results_seen;
    int                  cfg_writes;
    int                  stall_cycles;

    wind_speed_running_stats_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // speed in centihertz for one period at the current timebase,
    // zero for a zero period, clipped to the field width
    function automatic logic [SPEED_W-1:0] speed_from_period(input logic [23:0] period);
        logic [31:0] scaled;
        logic [31:0] quot;
        if (period == '0) begin
            return '0;
        end
        scaled = SPEED_SCALE * {{(32-TB_W){1'b0}}, cfg_timebase};
        quot   = scaled / {8'd0, period};
        if (quot > {{(32-SPEED_W){1'b0}}, SPEED_SAT}) begin
            quot = {{(32-SPEED_W){1'b0}}, SPEED_SAT};
        end
        return quot[SPEED_W-1:0];
    endfunction

    function automatic void clear_running_stats();
        stat_min   = MIN_EMPTY;
        stat_max   = '0;
        stat_sum   = '0;
        stat_count = '0;
    endfunction

    // folds one sample into the statistics and returns the result it causes
    function automatic speed_stats_t fold_speed_sample(input logic [23:0] period,
                                                       input logic clr);
        speed_stats_t     rec;
        logic [SPEED_W-1:0] spd;
        logic [ACC_W-1:0]   spd_wide;
        logic [ACC_W-1:0]   mean_wide;
        spd      = speed_from_period(period);
        spd_wide = {{(ACC_W-SPEED_W){1'b0}}, spd};
        if (clr) begin
            clear_running_stats();
        end
        if (spd_wide < stat_min) begin
            stat_min = spd_wide;
        end
        if (spd_wide > stat_max) begin
            stat_max = spd_wide;
        end
        // the sum wraps, the count sticks at its top value
        stat_sum = stat_sum + spd_wide;
        if (stat_count != COUNT_SAT) begin
            stat_count = stat_count + 1'b1;
        end
        mean_wide     = stat_sum / stat_count;
        rec.speed     = spd;
        rec.mean      = mean_wide[SPEED_W-1:0];
        rec.min_shown = (stat_min != MIN_EMPTY) ? stat_min[SPEED_W-1:0] : '0;
        rec.max_val   = stat_max[SPEED_W-1:0];
        return rec;
    endfunction

    // ------------------------------------------------------------------
    // reporting and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // every result transfer is checked against the oldest expectation
    always @(posedge aclk) begin
        speed_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected result", {5'd0, m_tdata[26:0]}, 32'd0);
            end else begin
                want = pending_stats.pop_front();
                if (m_tdata[26:0] != want.speed)
                    report_mismatch("speed", {5'd0, m_tdata[26:0]}, {5'd0, want.speed});
                if (m_tdata[53:27] != want.mean)
                    report_mismatch("speed_mean", {5'd0, m_tdata[53:27]},
                                    {5'd0, want.mean});
                if (m_tdata[80:54] != want.min_shown)
                    report_mismatch("speed_min", {5'd0, m_tdata[80:54]},
                                    {5'd0, want.min_shown});
                if (m_tdata[107:81] != want.max_val)
                    report_mismatch("speed_max", {5'd0, m_tdata[107:81]},
                                    {5'd0, want.max_val});
            end
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // watchdog: no transfer of any kind while work is outstanding
    always @(posedge aclk) begin
        if (!aresetn || (pending_stats.size() == 0 && !s_tvalid)) begin
            stall_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                     || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_stats.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // one input transfer; tvalid stays high on return so back-to-back
    // items need no extra assignment in the same step
    task automatic send_period(input logic [23:0] period, input logic clr);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= period;
        s_tuser  <= clr;
        do @(posedge aclk); while (!s_tready);
        pending_stats.push_back(fold_speed_sample(period, clr));
        items_sent++;
        @(negedge aclk);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(negedge aclk);
    endtask

    // timebase write followed by a read-back, only with the unit idle
    task automatic write_timebase(input logic [TB_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIMEBASE;
        pwdata  <= {{(32-TB_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_timebase = value;
        cfg_writes++;
        // read setup straight after the write access
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != {{(32-TB_W){1'b0}}, cfg_timebase})
            report_mismatch("timebase read-back", prdata, {{(32-TB_W){1'b0}}, cfg_timebase});
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mixture of zero, short, long, all-ones and full-range periods
    function automatic logic [23:0] random_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 24'($urandom_range(1, 64));
            3:       return '1;
            4, 5, 6: return 24'($urandom_range(1, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // statistics start empty after reset, timebase at its reset value
    task automatic test_reset_state();
        send_period(24'd1, 1'b0);
        send_period(24'd0, 1'b0);        // zero period still counts as a sample
        send_period(24'hFF_FFFF, 1'b0);
        send_period(24'd327, 1'b0);
    endtask

    // top, zero, unit and mid timebases with clipped and vanishing speeds
    task automatic test_timebase_extremes();
        write_timebase(TB_MAX);
        send_period(24'd1, 1'b1);        // quotient clipped to the field
        send_period(24'hFF_FFFF, 1'b0);
        send_period(24'd2, 1'b0);
        write_timebase('0);
        send_period(24'd1, 1'b1);        // zero timebase gives zero speed
        send_period(24'd5, 1'b0);
        send_period(24'd0, 1'b0);
        write_timebase(21'd1);
        send_period(24'd1, 1'b1);
        send_period(24'd101, 1'b0);
        send_period(24'd0, 1'b1);        // clear together with a zero period
        write_timebase(21'd1048576);
        send_period(24'd3, 1'b1);
        send_period(24'h80_0000, 1'b0);
    endtask

    // clipped speeds until the 32-bit sum wraps, mean follows the wrap
    task automatic test_sum_wrap();
        write_timebase(TB_MAX);
        send_period(24'd1, 1'b1);
        for (int k = 0; k < 34; k++) begin
            send_period(24'd1, 1'b0);
        end
    endtask

    // runs that mostly start with a clear, some noise clears inside;
    // an optional pause lets the unit drain completely mid-phase
    task automatic run_random_phase(input int n_items, input int pause_at);
        int   left;
        int   run_len;
        logic clr;
        left = n_items;
        while (left > 0) begin
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len && left > 0; k++) begin
                clr = (k == 0 && $urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 4);
                send_period(random_period(), clr);
                left--;
                if (n_items - left == pause_at) begin
                    drain_results();
                end
            end
        end
    endtask

    task automatic test_random_phases();
        write_timebase(21'($urandom_range(1, 1048576)));
        run_random_phase(PHASE_ITEMS, -1);
        // long stretch with both sides always ready
        idle_en = 1'b0;
        write_timebase(TB_MAX);
        run_random_phase(PHASE_ITEMS, -1);
        idle_en = 1'b1;
        write_timebase(TB_RESET);
        run_random_phase(PHASE_ITEMS, PHASE_ITEMS / 2);
        write_timebase(21'd1);
        run_random_phase(PHASE_ITEMS, -1);
        write_timebase(21'($urandom));
        run_random_phase(PHASE_ITEMS, -1);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_timebase = TB_RESET;
        clear_running_stats();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_timebase_extremes();
        test_sum_wrap();
        test_random_phases();

        drain_results();
        // quiet time to catch any stray result
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d items, %0d results and %0d timebase writes",
                 items_sent, results_seen, cfg_writes);
        $display("%0d mismatches, %0d results never arrived",
                 mismatches, pending_stats.size());
        if (mismatches == 0 && pending_stats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
